// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property, disabled while in reset
`define LSPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in this cycle, consequent in the next
`define LSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define LSPS_ASSERT(lbl, clk, rstn, prop, msg)
`define LSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/lsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lsps_pkg
// types, widths and constants of the line sensor pid steering block
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int NUM_SENSORS        = 6;
  localparam int SENSOR_W           = 10;
  localparam int GAIN_W             = 16;
  localparam int BASE_W             = 15;
  localparam int ERR_W              = 16;
  localparam int INT_W              = 32;
  localparam int OUT_W              = 16;
  localparam int DEF_GAIN_FRAC_BITS = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_BASE   = 2'd3
  } cfg_reg_t;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd2560;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;
  localparam logic [BASE_W-1:0]        BASE_RST   = 15'd2000;

  typedef logic [SENSOR_W-1:0]                 reading_t;
  // index 0 is the outermost right sensor, the last the outermost left
  typedef reading_t [NUM_SENSORS-1:0]          sensor_vec_t;

  // sensor weights in tenths, right to left
  localparam logic signed [ERR_W-1:0] WEIGHT_TENTHS [NUM_SENSORS] = '{
    -16'sd10, -16'sd5, -16'sd2, 16'sd2, 16'sd5, 16'sd10
  };

  // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for any x below 2**32
  localparam int              MAG_W       = 20;
  localparam logic [31:0]     RECIP_10    = 32'hCCCC_CCCD;
  localparam int              RECIP_SHIFT = 35;

endpackage

// ===== sv/lsps_if.sv =====
// ----------------------------------------------------------------------------
// lsps channel interfaces
// valid/ready channels for sensor items and steering result items
// ----------------------------------------------------------------------------
interface lsps_in_if;
  import lsps_pkg::*;

  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_ext_right;
  logic [SENSOR_W-1:0] sensor_right;
  logic [SENSOR_W-1:0] sensor_mid_right;
  logic [SENSOR_W-1:0] sensor_mid_left;
  logic [SENSOR_W-1:0] sensor_left;
  logic [SENSOR_W-1:0] sensor_ext_left;

  modport source (
    output valid, sensor_ext_right, sensor_right, sensor_mid_right,
           sensor_mid_left, sensor_left, sensor_ext_left,
    input  ready
  );

  modport sink (
    input  valid, sensor_ext_right, sensor_right, sensor_mid_right,
           sensor_mid_left, sensor_left, sensor_ext_left,
    output ready
  );
endinterface

interface lsps_out_if;
  import lsps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] line_error;
  logic signed [OUT_W-1:0] control_output;
  logic signed [OUT_W-1:0] right_velocity;
  logic signed [OUT_W-1:0] left_velocity;

  modport source (
    output valid, line_error, control_output, right_velocity, left_velocity,
    input  ready
  );

  modport sink (
    input  valid, line_error, control_output, right_velocity, left_velocity,
    output ready
  );
endinterface

// ===== sv/lsps_err_sum.sv =====
// ----------------------------------------------------------------------------
// lsps_err_sum
// weighted sum of the six sensor readings, line error in units of 1e-4
// ----------------------------------------------------------------------------
module lsps_err_sum (
  input  lsps_pkg::sensor_vec_t               sensors,
  output logic signed [lsps_pkg::ERR_W-1:0]   line_error
);
  import lsps_pkg::*;

  logic signed [ERR_W-1:0] acc;

  // readings up to 1023 keep every partial sum inside 16 bits
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      acc = acc + WEIGHT_TENTHS[i] * $signed(ERR_W'(sensors[i]));
    end
  end

  assign line_error = acc;

endmodule

// ===== sv/line_sensor_pid_steering.sv =====
// ----------------------------------------------------------------------------
// line_sensor_pid_steering
// pid steering from a weighted line sensor error, with saturating integral
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output takes results; the integral and
//   previous error loop closes in a single stage, and each stage holds one
//   item behind its own ready
// reset: gains and base speed take their defaults, integral and previous error
//   clear to zero, the pipeline empties
`include "assert_macros.svh"

module line_sensor_pid_steering #(
  parameter int GAIN_FRAC_BITS = lsps_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lsps_in_if.sink                           in_ch,
  lsps_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lsps_pkg::*;

  // pipeline stages
  localparam int ST_SENS = 1;
  localparam int ST_ERR  = 2;
  localparam int ST_INT  = 3;
  localparam int ST_MUL  = 4;
  localparam int ST_ACC  = 5;
  localparam int ST_MAG  = 6;
  localparam int ST_REC  = 7;
  localparam int ST_CTL  = 8;
  localparam int ST_OUT  = 9;
  localparam int NSTAGE  = ST_OUT;

  localparam int P_W      = GAIN_W + ERR_W;
  localparam int I_W      = GAIN_W + INT_W;
  localparam int D_W      = GAIN_W + ERR_W + 1;
  localparam int ACC_W    = I_W + 1;
  localparam int PROD_W   = MAG_W + 32;
  localparam int Q_W      = PROD_W - RECIP_SHIFT;
  localparam int SAT_IN_W = Q_W + 1;

  localparam logic signed [SAT_IN_W-1:0] OUT_MAX = SAT_IN_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [SAT_IN_W-1:0] OUT_MIN = -OUT_MAX - SAT_IN_W'(1);

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [BASE_W-1:0]        base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= GAIN_P_RST;
      ki_r   <= GAIN_I_RST;
      kd_r   <= GAIN_D_RST;
      base_r <= BASE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P: kp_r   <= cfg_wdata;
        REG_GAIN_I: ki_r   <= cfg_wdata;
        REG_GAIN_D: kd_r   <= cfg_wdata;
        REG_BASE:   base_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage handshake: a stage loads when it is empty or its item moves on
  logic [NSTAGE:1]   vld_r;
  logic [NSTAGE-1:0] vin;
  logic [NSTAGE+1:1] rdy;
  logic [NSTAGE:1]   ld;

  always_comb begin
    vin          = {vld_r[NSTAGE-1:1], in_ch.valid};
    rdy[NSTAGE+1] = out_ch.ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    for (int k = 1; k <= NSTAGE; k++) begin
      ld[k] = rdy[k] && vin[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k-1];
        end
      end
    end
  end

  assign in_ch.ready  = rdy[ST_SENS];
  assign out_ch.valid = vld_r[ST_OUT];

  // stage 1: input register
  sensor_vec_t sens_in, sens_r;

  assign sens_in[0] = in_ch.sensor_ext_right;
  assign sens_in[1] = in_ch.sensor_right;
  assign sens_in[2] = in_ch.sensor_mid_right;
  assign sens_in[3] = in_ch.sensor_mid_left;
  assign sens_in[4] = in_ch.sensor_left;
  assign sens_in[5] = in_ch.sensor_ext_left;

  always_ff @(posedge clk) begin
    if (ld[ST_SENS]) begin
      sens_r <= sens_in;
    end
  end

  // stage 2: weighted error
  logic signed [ERR_W-1:0] err_sum, err_r;

  lsps_err_sum u_err_sum (
    .sensors    (sens_r),
    .line_error (err_sum)
  );

  always_ff @(posedge clk) begin
    if (ld[ST_ERR]) begin
      err_r <= err_sum;
    end
  end

  // stage 3: integral and derivative; prev_err_r doubles as this stage's error
  logic signed [INT_W-1:0] integ_r, int_nxt;
  logic signed [INT_W:0]   int_sum;
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [ERR_W:0]   diff_nxt, diff_r;

  always_comb begin
    int_sum  = $signed({integ_r[INT_W-1], integ_r}) + (INT_W+1)'(err_r);
    diff_nxt = (ERR_W+1)'(err_r) - (ERR_W+1)'(prev_err_r);
    if (int_sum[INT_W] != int_sum[INT_W-1]) begin
      int_nxt = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      int_nxt = int_sum[INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else if (ld[ST_INT]) begin
      integ_r    <= int_nxt;
      prev_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_INT]) begin
      diff_r <= diff_nxt;
    end
  end

  // stage 4: gain products
  logic signed [P_W-1:0] p_r;
  logic signed [I_W-1:0] i_r;
  logic signed [D_W-1:0] d_r;

  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      p_r <= P_W'(kp_r) * P_W'(prev_err_r);
      i_r <= I_W'(ki_r) * I_W'(integ_r);
      d_r <= D_W'(kd_r) * D_W'(diff_r);
    end
  end

  // stage 5: sum of terms
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ld[ST_ACC]) begin
      acc_r <= ACC_W'(p_r) + ACC_W'(i_r) + ACC_W'(d_r);
    end
  end

  // stage 6: magnitude, drop fraction bits, clamp (anything clamped saturates)
  logic [ACC_W-1:0] absv, shv;
  logic [MAG_W-1:0] mag_nxt, mag_r;
  logic             neg6_r;

  always_comb begin
    absv    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    shv     = absv >> GAIN_FRAC_BITS;
    mag_nxt = (|shv[ACC_W-1:MAG_W]) ? {MAG_W{1'b1}} : shv[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[ST_MAG]) begin
      mag_r  <= mag_nxt;
      neg6_r <= acc_r[ACC_W-1];
    end
  end

  // stage 7: divide by ten through the reciprocal
  logic [PROD_W-1:0] rec_r;
  logic              neg7_r;

  always_ff @(posedge clk) begin
    if (ld[ST_REC]) begin
      rec_r  <= PROD_W'(mag_r) * PROD_W'(RECIP_10);
      neg7_r <= neg6_r;
    end
  end

  // stage 8: signed, saturated control value
  logic [Q_W-1:0]               quo;
  logic signed [SAT_IN_W-1:0]   ctl_full;
  logic signed [OUT_W-1:0]      ctl_r;

  always_comb begin
    quo      = rec_r[PROD_W-1:RECIP_SHIFT];
    ctl_full = neg7_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (ld[ST_CTL]) begin
      ctl_r <= sat_out(ctl_full);
    end
  end

  // line error travels alongside the arithmetic
  logic signed [ERR_W-1:0] eline_r [ST_MUL:ST_OUT];

  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      eline_r[ST_MUL] <= prev_err_r;
    end
    for (int k = ST_MUL + 1; k <= ST_OUT; k++) begin
      if (ld[k]) begin
        eline_r[k] <= eline_r[k-1];
      end
    end
  end

  // stage 9: wheel velocities, output register
  logic signed [SAT_IN_W-1:0] base_ext, ctl_ext;
  logic signed [OUT_W-1:0]    ctl_out_r, vr_r, vl_r;

  assign base_ext = SAT_IN_W'($signed({1'b0, base_r}));
  assign ctl_ext  = SAT_IN_W'(ctl_r);

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      ctl_out_r <= ctl_r;
      vr_r      <= sat_out(base_ext + ctl_ext);
      vl_r      <= sat_out(base_ext - ctl_ext);
    end
  end

  assign out_ch.line_error     = eline_r[ST_OUT];
  assign out_ch.control_output = ctl_out_r;
  assign out_ch.right_velocity = vr_r;
  assign out_ch.left_velocity  = vl_r;

  `LSPS_ASSERT(a_full_stall, clk, rst_n, ((&vld_r) && !out_ch.ready) |-> !in_ch.ready, "full and stalled")
  `LSPS_ASSERT_NEXT(a_state_hold, clk, rst_n, !ld[ST_INT], $stable(integ_r) && $stable(prev_err_r), "state moved")
  `LSPS_ASSERT_NEXT(a_prev_err, clk, rst_n, ld[ST_INT], prev_err_r == $past(err_r), "previous error")
  `LSPS_ASSERT(a_steer_dir, clk, rst_n, out_ch.valid |-> ((out_ch.control_output >= 0) == (out_ch.right_velocity >= out_ch.left_velocity)), "steer sign")

endmodule

// ===== verif/lsps_steering_checker.sv =====
// ----------------------------------------------------------------------------
// lsps_steering_checker
// watches the sensor, result and register ports of the steering block, keeps
// its own copy of gains, integral and previous error, and compares every
// result item field by field with the value worked out for it
// ----------------------------------------------------------------------------
module lsps_steering_checker #(
  parameter int FRAC_BITS = lsps_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsps_in_if                              in_ch,
  lsps_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  import lsps_pkg::*;

  typedef logic [SENSOR_W-1:0] sensor_row_t [NUM_SENSORS];

  typedef struct packed {
    logic signed [OUT_W-1:0] line_error;
    logic signed [OUT_W-1:0] control_output;
    logic signed [OUT_W-1:0] right_velocity;
    logic signed [OUT_W-1:0] left_velocity;
  } steer_result_t;

  // right to left, in tenths
  localparam int     TENTH_WEIGHTS [NUM_SENSORS] = '{-10, -5, -2, 2, 5, 10};
  localparam longint CTL_DIVISOR = 10 * (longint'(1) << FRAC_BITS);
  localparam longint INT_MAX     = 64'sd2147483647;
  localparam longint INT_MIN     = -64'sd2147483648;
  localparam longint OUT_MAX     = 64'sd32767;
  localparam longint OUT_MIN     = -64'sd32768;

  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;
  logic        [BASE_W-1:0] base_speed;
  logic signed [ERR_W-1:0]  last_error;
  logic signed [INT_W-1:0]  error_sum;

  steer_result_t expected_steering [$];
  int            mismatch_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // integral first, then the pid sum on the fresh integral
  function automatic steer_result_t predict_steering(input sensor_row_t rd);
    longint        err;
    longint        acc;
    longint        ctl;
    steer_result_t res;
    err = 0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      err += TENTH_WEIGHTS[k] * longint'(rd[k]);
    end
    error_sum = INT_W'(clamp(longint'(error_sum) + err, INT_MIN, INT_MAX));
    acc = longint'(gain_p) * err
        + longint'(gain_i) * longint'(error_sum)
        + longint'(gain_d) * (err - longint'(last_error));
    // signed divide truncates toward zero
    ctl = clamp(acc / CTL_DIVISOR, OUT_MIN, OUT_MAX);
    last_error = ERR_W'(err);
    res.line_error     = OUT_W'(err);
    res.control_output = OUT_W'(ctl);
    res.right_velocity = OUT_W'(clamp(longint'(base_speed) + ctl, OUT_MIN, OUT_MAX));
    res.left_velocity  = OUT_W'(clamp(longint'(base_speed) - ctl, OUT_MIN, OUT_MAX));
    return res;
  endfunction

  task automatic compare_field(input string name, input logic signed [OUT_W-1:0] want,
                               input logic signed [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    sensor_row_t   rd;
    steer_result_t want;
    if (!rst_n) begin
      gain_p     = 16'sd2560;
      gain_i     = '0;
      gain_d     = '0;
      base_speed = 15'd2000;
      last_error = '0;
      error_sum  = '0;
      expected_steering.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN_P: gain_p = cfg_wdata;
          REG_GAIN_I: gain_i = cfg_wdata;
          REG_GAIN_D: gain_d = cfg_wdata;
          REG_BASE:   base_speed = cfg_wdata[BASE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        rd[0] = in_ch.sensor_ext_right;
        rd[1] = in_ch.sensor_right;
        rd[2] = in_ch.sensor_mid_right;
        rd[3] = in_ch.sensor_mid_left;
        rd[4] = in_ch.sensor_left;
        rd[5] = in_ch.sensor_ext_left;
        expected_steering.push_back(predict_steering(rd));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_steering.size() == 0) begin
          $display("%0t: result item with none expected, expected nothing, actual error %0d",
                   $time, out_ch.line_error);
          mismatch_count++;
        end else begin
          want = expected_steering.pop_front();
          compare_field("line_error", want.line_error, out_ch.line_error);
          compare_field("control_output", want.control_output, out_ch.control_output);
          compare_field("right_velocity", want.right_velocity, out_ch.right_velocity);
          compare_field("left_velocity", want.left_velocity, out_ch.left_velocity);
        end
      end
    end
    mismatches  <= mismatch_count;
    outstanding <= expected_steering.size();
  end

endmodule

// ===== verif/tb_line_sensor_pid_steering.sv =====
// ----------------------------------------------------------------------------
// tb_line_sensor_pid_steering
// drives sensor items and register writes into the steering block with random
// gaps and stalls, ramps the integral both ways at full error, and gives
// the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module tb_line_sensor_pid_steering;
  import lsps_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  // longest quiet stretch in a good run is the long hold, well below this
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 185;
  // ramp lengths at full error: the integral climbs, falls as far below its
  // starting value, then comes back to where it started
  localparam int RAMP_UP       = 100;
  localparam int RAMP_DOWN     = 200;
  localparam int RAMP_BACK     = 100;

  typedef logic [SENSOR_W-1:0] reading_row_t [NUM_SENSORS];

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    src_gaps;
  bit                    sink_gaps;
  bit                    hold_req;
  int                    mismatches;
  int                    outstanding;

  lsps_in_if  in_if ();
  lsps_out_if out_if ();

  line_sensor_pid_steering uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lsps_steering_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic reading_row_t row_of(input int er, input int r, input int mr,
                                          input int ml, input int l, input int el);
    reading_row_t rd;
    rd[0] = reading_t'(er);
    rd[1] = reading_t'(r);
    rd[2] = reading_t'(mr);
    rd[3] = reading_t'(ml);
    rd[4] = reading_t'(l);
    rd[5] = reading_t'(el);
    return rd;
  endfunction

  function automatic reading_row_t random_row();
    reading_row_t rd;
    int           style;
    int           k;
    style = $urandom_range(0, 9);
    for (k = 0; k < NUM_SENSORS; k++) begin
      case (style)
        0, 1:    rd[k] = reading_t'($urandom_range(0, 1023));
        2:       rd[k] = $urandom_range(0, 1) ? reading_t'(1000) : reading_t'(0);
        default: rd[k] = reading_t'($urandom_range(0, 1000));
      endcase
    end
    return rd;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_gain();
    logic [CFG_DATA_W-1:0] g;
    case ($urandom_range(0, 5))
      0:       g = CFG_DATA_W'($urandom);
      1:       g = '0;
      2:       g = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: g = CFG_DATA_W'($urandom_range(0, 2048) - 1024);
    endcase
    return g;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_base();
    logic [BASE_W-1:0] b;
    b = $urandom_range(0, 2) == 0 ? BASE_W'($urandom) : BASE_W'($urandom_range(0, 4000));
    // top bit of the write data is not part of the register
    return {1'($urandom), b};
  endfunction

  // all four registers in a row; write enable drops once at the end
  task automatic program_regs(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                              input logic [CFG_DATA_W-1:0] kd,
                              input logic [CFG_DATA_W-1:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GAIN_P;
    cfg_wdata <= kp;
    @(posedge clk);
    cfg_index <= REG_GAIN_I;
    cfg_wdata <= ki;
    @(posedge clk);
    cfg_index <= REG_GAIN_D;
    cfg_wdata <= kd;
    @(posedge clk);
    cfg_index <= REG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_readings(input reading_row_t rd);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.sensor_ext_right <= rd[0];
    in_if.sensor_right     <= rd[1];
    in_if.sensor_mid_right <= rd[2];
    in_if.sensor_mid_left  <= rd[3];
    in_if.sensor_left      <= rd[4];
    in_if.sensor_ext_left  <= rd[5];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // outstanding is registered, so look only from the next edge on
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    reading_row_t left_max;
    reading_row_t right_max;
    int           ph;
    int           n;
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = REG_GAIN_P;
    cfg_wdata              = '0;
    in_if.valid            = 1'b0;
    in_if.sensor_ext_right = '0;
    in_if.sensor_right     = '0;
    in_if.sensor_mid_right = '0;
    in_if.sensor_mid_left  = '0;
    in_if.sensor_left      = '0;
    in_if.sensor_ext_left  = '0;
    out_if.ready           = 1'b0;
    src_gaps               = 1'b1;
    sink_gaps              = 1'b1;
    hold_req               = 1'b0;
    left_max  = row_of(0, 0, 0, 1023, 1023, 1023);
    right_max = row_of(1023, 1023, 1023, 0, 0, 0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains; readings above 1000 and the largest errors of both signs
    send_readings(row_of(0, 0, 0, 0, 0, 0));
    send_readings(row_of(1000, 1000, 1000, 1000, 1000, 1000));
    send_readings(row_of(1023, 1023, 1023, 1023, 1023, 1023));
    send_readings(right_max);
    send_readings(left_max);
    send_readings(row_of(1000, 0, 0, 0, 0, 0));
    send_readings(row_of(0, 1000, 0, 0, 0, 0));
    send_readings(row_of(0, 0, 1000, 0, 0, 0));
    send_readings(row_of(0, 0, 0, 1000, 0, 0));
    send_readings(row_of(0, 0, 0, 0, 1000, 0));
    send_readings(row_of(0, 0, 0, 0, 0, 1000));
    send_readings(row_of(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155));
    send_readings(row_of(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA));
    send_readings(row_of(1000, 0, 0, 0, 0, 1000));

    // control and both velocities pinned at the top and bottom
    settle();
    program_regs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_readings(left_max);
    send_readings(right_max);
    send_readings(row_of(0, 0, 0, 0, 0, 0));
    send_readings(left_max);
    settle();
    program_regs(16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_readings(left_max);
    send_readings(right_max);
    send_readings(row_of(0, 0, 0, 0, 0, 0));
    send_readings(left_max);

    // integral ramps at full error, back to back
    settle();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    program_regs(16'd256, 16'd1, 16'd0, 16'd1000);
    for (n = 0; n < RAMP_UP; n++) send_readings(left_max);
    for (n = 0; n < RAMP_DOWN; n++) send_readings(right_max);
    for (n = 0; n < RAMP_BACK; n++) send_readings(left_max);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      program_regs(random_gain(), random_gain(), random_gain(), random_base());
      // fill the pipeline against a stalled output
      if (ph == 2) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 60 == 0) begin
          if (ph < RANDOM_PHASES - 2) begin
            src_gaps  = $urandom_range(0, 2) != 0;
            sink_gaps = $urandom_range(0, 2) != 0;
          end else begin
            src_gaps  = 1'b0;
            sink_gaps = 1'b0;
          end
        end
        send_readings(random_row());
      end
    end

    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : result_sink
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
